@@ rtl/kped_pkg.sv @@
// Package for the key press event detector: field widths, register indexes,
// event codes and the press phase type. Depends on nothing.
`default_nettype none

package kped_pkg;

  // Payload and register widths
  localparam int unsigned KEY_W     = 3;
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_TICKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_TICKS = 1'd1;

  // Register reset values
  localparam logic [CNT_W-1:0] DEBOUNCE_TICKS_RST   = 8'd2;
  localparam logic [CNT_W-1:0] LONG_PRESS_TICKS_RST = 8'd200;

  // Event codes
  localparam logic EV_SHORT = 1'b0;
  localparam logic EV_LONG  = 1'b1;

  // Press phase: released, short press held, long press already reported
  typedef enum logic [1:0] {
    PH_RELEASED = 2'd0,
    PH_SHORT    = 2'd1,
    PH_LONG     = 2'd2
  } phase_t;

endpackage

`default_nettype wire

@@ rtl/kped_if.sv @@
// Valid/ready channel interfaces for the key press event detector: key input,
// event output and configuration write. Depends on kped_pkg.
`default_nettype none

interface kped_in_if;
  import kped_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_pins;

  modport source (output valid, output key_pins, input ready);
  modport sink   (input valid, input key_pins, output ready);
endinterface

interface kped_out_if;
  import kped_pkg::*;
  logic             valid;
  logic             ready;
  logic             event_kind;
  logic [KEY_W-1:0] event_keys;

  modport source (output valid, output event_kind, output event_keys, input ready);
  modport sink   (input valid, input event_kind, input event_keys, output ready);
endinterface

interface kped_cfg_if;
  import kped_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_DAT_W-1:0] wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

`default_nettype wire

@@ rtl/key_press_event_detector.sv @@
// Top level of the key press event detector: debounce, press tracking and
// short/long event generation. Depends on kped_pkg and the kped_if interfaces.
//
//   Channel   Direction  Payload                   Meaning
//   in_ch     sink       key_pins[2:0]             raw active-low pin levels, one per tick
//   out_ch    source     event_kind, event_keys    short or long press event
//   cfg_ch    sink       reg_index, wdata          debounce / long-press tick limits
//
// One tick is taken per cycle while the input register is not stalled. A transfer
// on in_ch is registered in the input register, decoded from it and any event
// is then loaded into the output register. The input register only stalls
// when it holds a tick and a finished event is still waiting on out_ch.
// Reset (rst_n low, synchronous) clears the key state and loads the register
// defaults of 2 and 200 ticks. Configuration transfers are always accepted.
`default_nettype none

module key_press_event_detector (
  input  wire logic     clk,
  input  wire logic     rst_n,
  kped_in_if.sink       in_ch,
  kped_out_if.source    out_ch,
  kped_cfg_if.sink      cfg_ch
);
  import kped_pkg::*;

  // Configuration registers
  logic [CNT_W-1:0] debounce_ticks_r;
  logic [CNT_W-1:0] long_press_ticks_r;

  // Input register
  logic             s1_valid_r;
  logic [KEY_W-1:0] pins_r;

  // Key state
  logic [KEY_W-1:0] last_mask_r,    last_mask_nxt;
  logic [CNT_W-1:0] steady_count_r, steady_count_nxt;
  phase_t           phase_r,        phase_nxt;
  logic [KEY_W-1:0] held_mask_r,    held_mask_nxt;

  // Output register
  logic             out_valid_r,    out_valid_nxt;
  logic             out_kind_r,     out_kind_nxt;
  logic [KEY_W-1:0] out_keys_r,     out_keys_nxt;

  // Step decode
  logic             s1_advance;
  logic             in_ready;
  logic [KEY_W-1:0] mask;
  logic             mask_changed;
  logic             below_long;
  logic [CNT_W-1:0] count_inc;
  logic             settle;
  logic             emit_short;
  logic             emit_long;
  logic             emit;

  // Configuration writes; the port never stalls.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_ticks_r   <= DEBOUNCE_TICKS_RST;
      long_press_ticks_r <= LONG_PRESS_TICKS_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        REG_DEBOUNCE_TICKS:   debounce_ticks_r   <= cfg_ch.wdata;
        REG_LONG_PRESS_TICKS: long_press_ticks_r <= cfg_ch.wdata;
        default: ;
      endcase
    end
  end

  // Handshake: the registered tick moves on when the output slot is free.
  assign s1_advance  = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready    = !s1_valid_r || s1_advance;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      pins_r <= in_ch.key_pins;
    end
  end

  // Decode of one tick against the stored key state.
  assign mask         = ~pins_r;
  assign mask_changed = (mask != last_mask_r);
  assign below_long   = (steady_count_r < long_press_ticks_r);
  assign count_inc    = steady_count_r + CNT_W'(1);
  assign settle       = !mask_changed && below_long && (count_inc == debounce_ticks_r);
  assign emit_short   = settle && (mask == '0) && (phase_r == PH_SHORT);
  assign emit_long    = !mask_changed && !below_long && (phase_r != PH_LONG);
  assign emit         = emit_short || emit_long;

  // Next key state.
  always_comb begin
    last_mask_nxt    = last_mask_r;
    steady_count_nxt = steady_count_r;
    phase_nxt        = phase_r;
    held_mask_nxt    = held_mask_r;
    if (mask_changed) begin
      steady_count_nxt = '0;
      last_mask_nxt    = mask;
    end else if (below_long) begin
      steady_count_nxt = count_inc;
      if (settle) begin
        if (mask == '0) begin
          // Settled release ends the press and restarts the count.
          steady_count_nxt = '0;
          phase_nxt        = PH_RELEASED;
          held_mask_nxt    = '0;
        end else begin
          phase_nxt = PH_SHORT;
          if (held_mask_r < mask) begin
            held_mask_nxt = mask;
          end
        end
      end
    end else if (phase_r != PH_LONG) begin
      phase_nxt = PH_LONG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_mask_r    <= '0;
      steady_count_r <= '0;
      phase_r        <= PH_RELEASED;
      held_mask_r    <= '0;
    end else if (s1_advance) begin
      last_mask_r    <= last_mask_nxt;
      steady_count_r <= steady_count_nxt;
      phase_r        <= phase_nxt;
      held_mask_r    <= held_mask_nxt;
    end
  end

  // Output register: load an event, or drop the one taken this cycle.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_keys_nxt  = out_keys_r;
    if (s1_advance && emit) begin
      out_valid_nxt = 1'b1;
      out_kind_nxt  = emit_long ? EV_LONG : EV_SHORT;
      out_keys_nxt  = held_mask_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_keys_r <= out_keys_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.event_kind = out_kind_r;
  assign out_ch.event_keys = out_keys_r;

`ifndef SYNTHESIS
  // A reported long press moves the phase to long-reported.
  a_long_sets_phase: assert property (@(posedge clk) disable iff (!rst_n)
    s1_advance && emit_long |=> phase_r == PH_LONG)
    else $error("long event without phase update");

  // An event only appears after a tick has been processed.
  a_event_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_advance))
    else $error("output event without a processed tick");

  // No held mask survives a settled release.
  a_released_clear: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_RELEASED |-> held_mask_r == '0)
    else $error("held mask set while released");

  // The input only stalls behind a waiting event.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a waiting event");
`endif

endmodule

`default_nettype wire

@@ bench/tb_key_press_event_detector.sv @@
// Testbench for key_press_event_detector: drives raw key ticks, predicts
// short and long press events and checks every event transfer in order.
// Depends on kped_pkg, the kped_if interfaces and the detector RTL.

module tb_key_press_event_detector;
  import kped_pkg::*;

  localparam int SETTLE_CYCLES = 6;
  localparam int DRAIN_LIMIT   = 5000;

  typedef struct packed {
    logic             kind;
    logic [KEY_W-1:0] keys;
  } key_event_t;

  logic clk;
  logic rst_n;

  kped_in_if  in_ch ();
  kped_out_if out_ch ();
  kped_cfg_if cfg_ch ();

  key_press_event_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Events the detector still owes us, oldest first.
  key_event_t pending_events[$];
  int         error_count = 0;
  int         ticks_sent  = 0;
  int         burst_left  = 0;

  // Own copy of the detector's limits and key tracking state.
  logic [CNT_W-1:0] debounce_lim;
  logic [CNT_W-1:0] long_lim;
  logic [CNT_W-1:0] steady_count;
  logic [KEY_W-1:0] prev_mask;
  logic [KEY_W-1:0] held_mask;
  phase_t           phase;

  // Receiver stall pattern state.
  int stall_mode = 0;
  int seg_left   = 0;
  int run_left   = 0;
  bit rx_ready   = 1'b0;

  // Clock with a period of 10.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Advance the key tracker by one tick; returns 1 when the tick yields an event.
  function automatic bit predict_tick(input logic [KEY_W-1:0] pins, output key_event_t ev);
    logic [KEY_W-1:0] mask;
    bit               fired;
    mask  = ~pins;
    ev    = '0;
    fired = 1'b0;
    if (mask != prev_mask) begin
      steady_count = '0;
      prev_mask    = mask;
      return 1'b0;
    end
    if (steady_count < long_lim) begin
      steady_count = steady_count + 1'b1;
      if (steady_count == debounce_lim) begin
        if (mask == '0) begin
          // A settled release ends the press; only a short press reports it.
          steady_count = '0;
          fired        = (phase == PH_SHORT);
          ev           = '{kind: EV_SHORT, keys: held_mask};
          phase        = PH_RELEASED;
          held_mask    = '0;
          return fired;
        end
        phase = PH_SHORT;
        if (held_mask < mask) held_mask = mask;
      end
      return 1'b0;
    end
    // Long limit reached: report once per press, whatever the keys are now.
    if (phase != PH_LONG) begin
      ev    = '{kind: EV_LONG, keys: held_mask};
      phase = PH_LONG;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Send one tick, with bursts of transfers separated by random idle gaps.
  task automatic send_tick(input logic [KEY_W-1:0] pins);
    int         gap;
    key_event_t ev;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 60);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_ch.valid    <= 1'b0;
        in_ch.key_pins <= 3'($urandom_range(0, 7));
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.key_pins <= pins;
    do @(posedge clk); while (!in_ch.ready);
    ticks_sent++;
    if (predict_tick(pins, ev)) pending_events.push_back(ev);
  endtask

  task automatic send_hold(input logic [KEY_W-1:0] pins, input int count);
    repeat (count) send_tick(pins);
  endtask

  // Wait until every owed event has arrived, then let the pipeline empty.
  task automatic drain_events();
    int waited;
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pending_events.size() != 0) begin
      $display("%0t: %0d expected events never arrived, oldest kind %0d keys %0d",
               $time, pending_events.size(), pending_events[0].kind, pending_events[0].keys);
      error_count++;
      pending_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == REG_DEBOUNCE_TICKS) debounce_lim = data;
    else long_lim = data;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Limits are only changed once the detector has gone quiet.
  task automatic set_limits(input int deb, input int lim);
    drain_events();
    write_reg(REG_DEBOUNCE_TICKS, CFG_DAT_W'(deb));
    write_reg(REG_LONG_PRESS_TICKS, CFG_DAT_W'(lim));
  endtask

  // One press episode: mostly a clean press and release, sometimes bounce or noise.
  task automatic random_episode();
    int               settle;
    int               long_n;
    int               n;
    int               hi;
    int               pick;
    logic [KEY_W-1:0] mask;
    logic [KEY_W-1:0] other;
    settle = int'(debounce_lim) + 1;
    long_n = int'(long_lim) + 1;
    pick   = $urandom_range(0, 99);
    if (pick < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) send_tick(3'($urandom_range(0, 7)));
      return;
    end
    mask = 3'($urandom_range(1, 7));
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      n = $urandom_range(1, settle);
    end else if (pick < 70) begin
      hi = settle;
      if (long_n - 1 > settle) hi = (long_n - 1 < settle + 12) ? long_n - 1 : settle + 12;
      n = $urandom_range(settle, hi);
    end else begin
      n = $urandom_range(long_n, long_n + 4);
    end
    send_hold(~mask, n);
    // Occasionally roll into a different chord before letting go.
    if ($urandom_range(0, 2) == 0) begin
      other = 3'($urandom_range(1, 7));
      send_hold(~other, $urandom_range(1, settle + 3));
    end
    if ($urandom_range(0, 4) == 0) n = $urandom_range(1, settle);
    else n = $urandom_range(settle, settle + 4);
    send_hold(3'b111, n);
  endtask

  // Short press of key0 with the reset limits.
  task automatic test_short_press_defaults();
    send_hold(3'b110, 3);
    send_hold(3'b111, 3);
  endtask

  // Long press of all keys, then a chord that grows and shrinks.
  task automatic test_chords_and_long();
    set_limits(1, 3);
    send_hold(3'b000, 5);
    send_hold(3'b111, 2);
    send_hold(3'b101, 2);
    send_hold(3'b001, 2);
    send_hold(3'b011, 2);
    send_hold(3'b111, 2);
  endtask

  // Zero long limit, long limit on released keys and a zero debounce.
  task automatic test_special_cases();
    set_limits(2, 0);
    send_hold(3'b011, 2);
    set_limits(1, 3);
    send_hold(3'b111, 2);
    set_limits(5, 3);
    send_hold(3'b111, 4);
    set_limits(0, 4);
    send_hold(3'b110, 4);
  endtask

  task automatic test_random_phase(input int deb, input int lim, input int budget);
    int target;
    set_limits(deb, lim);
    target = ticks_sent + budget;
    while (ticks_sent < target) random_episode();
  endtask

  task automatic test_random();
    int deb;
    int k;
    test_random_phase(1, 2, 150);
    test_random_phase(3, 12, 150);
    test_random_phase(1, 255, 150);
    test_random_phase(254, 255, 260);
    for (k = 0; k < 3; k++) begin
      deb = $urandom_range(1, 8);
      test_random_phase(deb, $urandom_range(deb + 1, 40), 100);
    end
    test_random_phase(0, 10, 60);
    test_random_phase(9, 4, 60);
    test_random_phase(5, 0, 40);
    test_random_phase(2, 200, 60);
  endtask

  // Receiver: modes of full speed, light and heavy random stalls, and long stalls.
  always @(negedge clk) begin
    if (seg_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      seg_left   = $urandom_range(20, 200);
    end
    seg_left--;
    case (stall_mode)
      0: begin
        rx_ready = 1'b1;
      end
      1: begin
        rx_ready = ($urandom_range(0, 3) != 0);
      end
      2: begin
        rx_ready = ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (run_left == 0) begin
          rx_ready = !rx_ready;
          run_left = rx_ready ? $urandom_range(1, 3) : $urandom_range(5, 25);
        end
        run_left--;
      end
    endcase
    out_ch.ready <= rx_ready;
  end

  // Compare each event transfer with the oldest prediction.
  always @(posedge clk) begin
    key_event_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: event with none expected, kind %0d keys %0d",
                 $time, out_ch.event_kind, out_ch.event_keys);
        error_count++;
      end else begin
        want = pending_events.pop_front();
        if (out_ch.event_kind !== want.kind) begin
          $display("%0t: event_kind mismatch, expected %0d, actual %0d",
                   $time, want.kind, out_ch.event_kind);
          error_count++;
        end
        if (out_ch.event_keys !== want.keys) begin
          $display("%0t: event_keys mismatch, expected %0d, actual %0d",
                   $time, want.keys, out_ch.event_keys);
          error_count++;
        end
      end
    end
  end

  // Main sequence: reset, directed tests, random tests, final verdict.
  initial begin
    in_ch.valid      = 1'b0;
    in_ch.key_pins   = '1;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = REG_DEBOUNCE_TICKS;
    cfg_ch.wdata     = '0;
    rst_n            = 1'b0;
    debounce_lim     = DEBOUNCE_TICKS_RST;
    long_lim         = LONG_PRESS_TICKS_RST;
    steady_count     = '0;
    prev_mask        = '0;
    held_mask        = '0;
    phase            = PH_RELEASED;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_short_press_defaults();
    test_chords_and_long();
    test_special_cases();
    test_random();

    drain_events();
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #3000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
